// ----- rtl/core/u8u16_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared payload types, job descriptor and code point constants.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    // One byte of the source string.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_item;

    // One UTF-16 result.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        decode_error;
        logic        string_end;
        logic        run_last;
    } t_result;

    // Number of continuation bytes in the sequence being gathered.
    typedef enum logic [1:0] {
        LEN_NONE  = 2'd0,
        LEN_TWO   = 2'd1,
        LEN_THREE = 2'd2,
        LEN_FOUR  = 2'd3
    } t_len_class;

    // What the back end has to produce for one queued job.
    typedef enum logic [1:0] {
        JOB_UNIT  = 2'd0,
        JOB_PAIR  = 2'd1,
        JOB_ERROR = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [20:0] point;
        logic        fin;
    } t_job;

    localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
    localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;
    localparam logic [20:0] SURR_FIRST     = 21'h00D800;
    localparam logic [20:0] SURR_LAST      = 21'h00DFFF;
    localparam logic [20:0] MAX_POINT      = 21'h10FFFF;
    localparam logic [20:0] PLANE1_BASE    = 21'h010000;
    localparam logic [20:0] BMP_LAST       = 21'h00FFFF;
    localparam logic [20:0] MIN_TWO        = 21'h000080;
    localparam logic [20:0] MIN_THREE      = 21'h000800;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [1:0] CONT_TAG   = 2'b10;

endpackage

// ----- rtl/core/u8u16_front.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder front end
// Decodes one byte per transfer, keeps the partial code point and posts a job
// for every byte that gives results.
// ----------------------------------------------------------------------------
module u8u16_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  u8u16_pkg::t_item  i_item,
    output logic              o_job_valid,
    output u8u16_pkg::t_job   o_job
);

    logic [20:0]           r_point, n_point;
    logic [1:0]            r_pending, n_pending;
    u8u16_pkg::t_len_class r_class, n_class;
    logic                  r_err, n_err;

    logic [7:0]  b;
    logic        fin;
    logic [20:0] acc_point;
    logic [20:0] minimum;
    logic        do_fail;
    logic        do_err_end;
    logic        lead_ok;

    assign b         = i_item.data_byte;
    assign fin       = i_item.final_byte;
    assign acc_point = {r_point[14:0], b[5:0]};

    always_comb begin
        unique case (r_class)
            u8u16_pkg::LEN_TWO:   minimum = u8u16_pkg::MIN_TWO;
            u8u16_pkg::LEN_THREE: minimum = u8u16_pkg::MIN_THREE;
            default:              minimum = u8u16_pkg::PLANE1_BASE;
        endcase
    end

    always_comb begin
        n_point     = r_point;
        n_pending   = r_pending;
        n_class     = r_class;
        n_err       = r_err;
        o_job_valid = 1'b0;
        o_job       = '{kind: u8u16_pkg::JOB_UNIT, point: '0, fin: fin};
        do_fail     = 1'b0;
        do_err_end  = 1'b0;
        lead_ok     = 1'b0;

        if (i_accept) begin
            if (r_err) begin
                do_err_end = fin;
            end else if (r_pending == 2'd0) begin
                if (!b[7]) begin
                    o_job_valid = 1'b1;
                    o_job.point = {13'd0, b};
                end else if ((b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_CODE) begin
                    lead_ok = 1'b1;
                    n_point = {16'd0, b[4:0]};
                    n_class = u8u16_pkg::LEN_TWO;
                end else if ((b & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_CODE) begin
                    lead_ok = 1'b1;
                    n_point = {17'd0, b[3:0]};
                    n_class = u8u16_pkg::LEN_THREE;
                end else if ((b & u8u16_pkg::LEAD4_MASK) == u8u16_pkg::LEAD4_CODE) begin
                    lead_ok = 1'b1;
                    n_point = {18'd0, b[2:0]};
                    n_class = u8u16_pkg::LEN_FOUR;
                end else begin
                    do_fail = 1'b1;
                end
                if (lead_ok) begin
                    n_pending  = 2'(n_class);
                    do_err_end = fin;
                end
            end else if (b[7:6] != u8u16_pkg::CONT_TAG) begin
                do_fail = 1'b1;
            end else begin
                n_pending = r_pending - 2'd1;
                if (n_pending != 2'd0) begin
                    n_point    = acc_point;
                    do_err_end = fin;
                end else begin
                    n_point = '0;
                    n_class = u8u16_pkg::LEN_NONE;
                    if (acc_point < minimum || acc_point > u8u16_pkg::MAX_POINT ||
                        (acc_point >= u8u16_pkg::SURR_FIRST &&
                         acc_point <= u8u16_pkg::SURR_LAST)) begin
                        do_fail = 1'b1;
                    end else begin
                        o_job_valid = 1'b1;
                        o_job.point = acc_point;
                        o_job.kind  = (acc_point > u8u16_pkg::BMP_LAST) ?
                                      u8u16_pkg::JOB_PAIR : u8u16_pkg::JOB_UNIT;
                    end
                end
            end

            if (do_fail) begin
                if (fin) begin
                    do_err_end = 1'b1;
                end else begin
                    n_err     = 1'b1;
                    n_point   = '0;
                    n_pending = 2'd0;
                    n_class   = u8u16_pkg::LEN_NONE;
                end
            end

            if (do_err_end) begin
                o_job_valid = 1'b1;
                o_job.kind  = u8u16_pkg::JOB_ERROR;
                o_job.point = '0;
            end

            // The end of a string always leaves the decoder clean.
            if (fin) begin
                n_err     = 1'b0;
                n_point   = '0;
                n_pending = 2'd0;
                n_class   = u8u16_pkg::LEN_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point   <= '0;
            r_pending <= 2'd0;
            r_class   <= u8u16_pkg::LEN_NONE;
            r_err     <= 1'b0;
        end else begin
            r_point   <= n_point;
            r_pending <= n_pending;
            r_class   <= n_class;
            r_err     <= n_err;
        end
    end

    // A latched error discards the sequence in progress.
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> (r_pending == 2'd0 && r_class == u8u16_pkg::LEN_NONE))
        else $error("front: error latched with a sequence in progress");

    // Pending count never exceeds the length class of the sequence.
    a_pending_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 2'(r_class))
        else $error("front: pending count beyond length class");

    // Error jobs always close the string.
    a_err_job_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_valid && o_job.kind == u8u16_pkg::JOB_ERROR) |-> fin)
        else $error("front: error job posted before the final byte");

endmodule

// ----- rtl/core/u8u16_jobq.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder job queue
// Small register queue decoupling the decoder from the result sequencer.
// ----------------------------------------------------------------------------
module u8u16_jobq #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  u8u16_pkg::t_job  i_job,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_avail,
    output u8u16_pkg::t_job  o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u8u16_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_avail = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("jobq: job posted while the queue is full");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("jobq: occupancy beyond depth");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("jobq: pointers disagree on an empty queue");

endmodule

// ----- rtl/core/u8u16_back.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder back end
// Turns queued jobs into UTF-16 results, splitting supplementary code points
// into surrogate pairs, and holds the result register.
// ----------------------------------------------------------------------------
module u8u16_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_avail,
    input  u8u16_pkg::t_job   i_job,
    output logic              o_job_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output u8u16_pkg::t_result o_result
);

    logic               r_out_valid;
    u8u16_pkg::t_result r_out, n_out;
    logic               r_low_pending, n_low_pending;
    logic               load;
    logic [20:0]        offset;

    assign load     = !r_out_valid || i_pop;
    assign offset   = i_job.point - u8u16_pkg::PLANE1_BASE;
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_low_pending = r_low_pending;
        o_job_pop     = 1'b0;
        n_out         = '0;
        unique case (i_job.kind)
            u8u16_pkg::JOB_ERROR: begin
                n_out.decode_error = 1'b1;
                n_out.string_end   = 1'b1;
                n_out.run_last     = 1'b1;
            end
            u8u16_pkg::JOB_PAIR: begin
                n_out.unit_valid = 1'b1;
                if (r_low_pending) begin
                    n_out.code_unit  = u8u16_pkg::SURR_LOW_BASE + {6'd0, offset[9:0]};
                    n_out.string_end = i_job.fin;
                    n_out.run_last   = 1'b1;
                end else begin
                    n_out.code_unit  = u8u16_pkg::SURR_HIGH_BASE + {6'd0, offset[19:10]};
                end
            end
            default: begin
                n_out.code_unit  = i_job.point[15:0];
                n_out.unit_valid = 1'b1;
                n_out.string_end = i_job.fin;
                n_out.run_last   = 1'b1;
            end
        endcase

        if (load && i_job_avail) begin
            if (i_job.kind == u8u16_pkg::JOB_PAIR && !r_low_pending) begin
                n_low_pending = 1'b1;
            end else begin
                n_low_pending = 1'b0;
                o_job_pop     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_job_avail) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_low_pending <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= i_job_avail;
            end
            r_low_pending <= n_low_pending;
        end
    end

    // The low half of a pair is owed only while its job heads the queue.
    a_low_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low_pending |-> (i_job_avail && i_job.kind == u8u16_pkg::JOB_PAIR))
        else $error("back: low surrogate owed without a pair job");

    // A held result that is not the last of its byte is a high surrogate.
    a_high_then_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.run_last) |-> r_low_pending)
        else $error("back: high surrogate held without its low half owed");

    // An error result never carries a unit.
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.decode_error) |->
            (!r_out.unit_valid && r_out.string_end && r_out.code_unit == '0))
        else $error("back: malformed error result");

endmodule

// ----- rtl/core/utf8_to_utf16_transcoder.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Streams UTF-8 bytes in and UTF-16 code units out, flagging malformed strings
// on the result that closes them.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake      Payload
//  --------  ---------  -------------  --------------------------------------
//  input     in         push / full    i_item   (data_byte, final_byte)
//  result    out        pop / empty    o_result (code_unit, unit_valid,
//                                               decode_error, string_end,
//                                               run_last)
//
//  One byte is taken per cycle while full is low. The byte is decoded and its
//  job written into the queue at its transfer; a later edge moves the result
//  from the queue head into the output register, from which it can be popped.
//  A supplementary character takes the result register once for each surrogate;
//  apart from a withheld pop, that is the only place the result side runs
//  slower than one job per cycle, and the job queue absorbs it.
//  Reset is synchronous and active low; it empties the queue and the result
//  register and clears the decoder state. No sweep is needed after reset.
//  full rises when the job queue holds QUEUE_DEPTH jobs, which happens only
//  while the consumer withholds pop or surrogate pairs pile up.
//
module utf8_to_utf16_transcoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  u8u16_pkg::t_item    i_item,
    output logic                empty,
    input  logic                pop,
    output u8u16_pkg::t_result  o_result
);

    // A byte is decoded in the very cycle it is transferred.
    logic            accept;
    logic            job_valid;
    u8u16_pkg::t_job job;

    // Queue head as seen by the result sequencer.
    logic            job_avail;
    logic            job_pop;
    u8u16_pkg::t_job head;

    assign accept = push && !full;

    // Front end: classifies the byte, tracks the sequence and posts a job for
    // each byte that yields a unit, a pair or the error closing a string.
    u8u16_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    // Decoupling queue between decode and result sequencing.
    u8u16_jobq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_job   (job),
        .i_pop   (job_pop),
        .o_full  (full),
        .o_avail (job_avail),
        .o_head  (head)
    );

    // Back end: expands jobs into results and presents them through the
    // output register, so the next result loads in the cycle one is taken.
    u8u16_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_avail (job_avail),
        .i_job       (head),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule
